// ===== design/quicksort_sorter_top_macros.svh =====
// Assertion macros shared by the sorter checker.
`ifndef QUICKSORT_SORTER_TOP_MACROS_SVH
`define QUICKSORT_SORTER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define QSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define QSS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== design/qss_pkg.sv =====
// Types and constants shared by the sorter modules.
package qss_pkg;

	localparam int DATA_W = 32;

	typedef enum logic {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Row-wide command to every cell
	typedef struct packed {
		logic ins;    // insert broadcast value in order
		logic shift;  // move row one place toward the head
	} cell_ctl_t;

	// What a cell shows its neighbors
	typedef struct packed {
		logic                     valid;
		logic                     gt;     // empty, or holds a value above the broadcast
		logic signed [DATA_W-1:0] value;
	} cell_link_t;

endpackage

// ===== design/quicksort_sorter_top.sv =====
// Top level of the streaming sorter: load, order, emit.
//
// Sorts a set of signed 32-bit values into ascending order. Values arrive one
// request per cycle on the s_ side; s_tlast marks the final value of a set.
// Ordering happens while loading: the values sit in a row of MAX_ITEMS cells
// kept in ascending order, every cell compares its value against the incoming
// one and the cells above the insertion point hand their value one place up.
// Once the last value is in, the set streams out on the m_ side, smallest
// first, one request per cycle while m_tready is high, the row shifting one
// place toward the head on each; s_tready is low while a set is being
// emitted. The per-cycle limit is one 32-bit signed compare at each cell.
// Values offered past MAX_ITEMS are dropped, and every result of that set then
// carries the overflow flag in m_tuser. A final value that is dropped still
// ends the set. Equal values are emitted as repeated values.
module quicksort_sorter_top import qss_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic                     s_tlast,   // is_last
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic signed [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
	output logic                     m_tlast,   // last_out
	output logic                     m_tuser    // [0] overflow
);

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             in_acc, out_acc, full;
	logic             head_last;
	cell_ctl_t        ctl;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign full    = (count_q == CNT_W'(MAX_ITEMS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && s_tlast) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_acc && head_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_LOAD: s_tready = 1'b1;
			ST_EMIT: m_tvalid = 1'b1;
			default: begin
				s_tready = 1'b0;
				m_tvalid = 1'b0;
			end
		endcase
	end

	assign ctl.ins   = in_acc && !full;
	assign ctl.shift = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (full) ovf_q <= 1'b1;
				else      count_q <= count_q + CNT_W'(1);
			end
			if (out_acc && head_last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	qss_chain #(
		.N (MAX_ITEMS)
	) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.x          (s_tdata),
		.head_value (m_tdata),
		.head_last  (head_last)
	);

	assign m_tlast = head_last;
	assign m_tuser = ovf_q;

endmodule

// ===== design/qss_cell.sv =====
// One sorting cell: holds one value of the ordered row.
module qss_cell import qss_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] x,
	input  cell_link_t               left,
	input  cell_link_t               right,
	output cell_link_t               link
);

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     gt;

	assign gt         = !valid_q || (value_q > x);
	assign link.valid = valid_q;
	assign link.gt    = gt;
	assign link.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= right.valid;
		end else if (ctl.ins && gt) begin
			valid_q <= left.gt ? left.valid : 1'b1;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= right.value;
		end else if (ctl.ins && gt) begin
			value_q <= left.gt ? left.value : x;
		end
	end

endmodule

// ===== design/qss_chain.sv =====
// Row of sorting cells kept in ascending order, head at cell 0.
module qss_chain import qss_pkg::*; #(
	parameter int N = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] x,
	output logic signed [DATA_W-1:0] head_value,
	output logic                     head_last
);

	cell_link_t links [N];
	cell_link_t lefts [N];
	cell_link_t rights[N];

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			if (i == 0) begin : g_head
				// head's left acts as a valid cell below any value
				assign lefts[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
			end else begin : g_mid
				assign lefts[i] = links[i-1];
			end
			if (i == N-1) begin : g_tail
				assign rights[i] = '{valid: 1'b0, gt: 1'b1, value: '0};
			end else begin : g_body
				assign rights[i] = links[i+1];
			end
			qss_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.x      (x),
				.left   (lefts[i]),
				.right  (rights[i]),
				.link   (links[i])
			);
		end
	endgenerate

	assign head_value = links[0].value;
	assign head_last  = !links[1].valid;

endmodule

// ===== design/qss_checker.sv =====
// Port-level checker for the sorter, bound to the top level.
`include "quicksort_sorter_top_macros.svh"

module qss_checker import qss_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     s_tlast,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic signed [DATA_W-1:0] m_tdata,
	input logic                     m_tlast,
	input logic                     m_tuser
);

	// loading and emitting never overlap
	`QSS_NEVER(a_no_overlap, s_tready && m_tvalid, "load and emit overlap")

	// end of set starts emitting at once
	`QSS_ASSERT(a_emit_start, s_tvalid && s_tready && s_tlast |=> m_tvalid, "emit did not start")

	// last result returns the block to loading
	`QSS_ASSERT(a_back_to_load, m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid, "no return to load")

	// overflow flag is constant across one set's results
	`QSS_ASSERT(a_ovf_steady, m_tvalid && m_tready && !m_tlast |=> m_tuser == $past(m_tuser), "overflow changed within set")

	// stalled result holds
	`QSS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind quicksort_sorter_top qss_checker u_qss_checker (.*);

// ===== sim/quicksort_sorter_top_tb.sv =====
// Testbench for quicksort_sorter_top: random sets streamed in, sorted output checked.
module quicksort_sorter_top_tb import qss_pkg::*;;

	localparam int SET_CAP      = 64;
	localparam int IDLE_LIMIT   = 50000;
	localparam int SETTLE_TICKS = 64;
	localparam int RAND_ITEMS   = 107;
	localparam int DIR_ITEMS    = 23;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		int                       gap;    // idle cycles before this request
		bit                       drain;  // hold until all sorted output is back
	} load_req_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} sorted_item_t;

	// directed sets: single zero, single minimum, extremes, duplicates,
	// already ascending, descending
	localparam logic [DATA_W-1:0] DIR_VALS [DIR_ITEMS] = '{
		32'h0000_0000,
		32'h8000_0000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
		32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFB,
		32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
		32'h0000_0002,
		32'h0000_0064, 32'h0000_0032, 32'h0000_0000, 32'hFFFF_FFCE, 32'hFFFF_FF9C
	};
	localparam logic [DIR_ITEMS-1:0] DIR_LAST =
		(23'd1 << 0) | (23'd1 << 1) | (23'd1 << 6) | (23'd1 << 11) |
		(23'd1 << 17) | (23'd1 << 22);

	logic                     clk      = 1'b0;
	logic                     arst_n   = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic signed [DATA_W-1:0] s_tdata  = '0;
	logic                     s_tlast  = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic signed [DATA_W-1:0] m_tdata;
	logic                     m_tlast;
	logic                     m_tuser;

	load_req_t                load_queue [$];
	sorted_item_t             sorted_due [$];
	logic signed [DATA_W-1:0] set_vals   [$];
	logic                     set_overflow = 1'b0;

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  gap_left = -1;
	int  stall_left = 0;
	bit  rx_busy = 1'b1;
	bit  tx_valid;
	load_req_t tx_req;
	sorted_item_t got;

	quicksort_sorter_top #(
		.MAX_ITEMS(SET_CAP)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Store one accepted value; a final value sorts the set and queues its output.
	task automatic load_value(input logic signed [DATA_W-1:0] v, input logic last);
		logic signed [DATA_W-1:0] key;
		sorted_item_t             r;
		int                       i;
		int                       j;
		if (set_vals.size() < SET_CAP)
			set_vals.push_back(v);
		else
			set_overflow = 1'b1;
		if (last) begin
			for (i = 1; i < set_vals.size(); i++) begin
				key = set_vals[i];
				j = i - 1;
				while (j >= 0 && set_vals[j] > key) begin
					set_vals[j+1] = set_vals[j];
					j--;
				end
				set_vals[j+1] = key;
			end
			for (i = 0; i < set_vals.size(); i++) begin
				r.value = set_vals[i];
				r.last  = (i == set_vals.size() - 1);
				r.ovf   = set_overflow;
				sorted_due.push_back(r);
			end
			set_vals.delete();
			set_overflow = 1'b0;
		end
	endtask

	task automatic push_req(input logic [DATA_W-1:0] v, input logic last, input int gap,
			input bit drain);
		load_req_t q;
		q.value = v;
		q.last  = last;
		q.gap   = gap;
		q.drain = drain;
		load_queue.push_back(q);
	endtask

	// Mix of full-range values, a narrow band for duplicates and the extremes.
	function automatic logic [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			6, 7:    return DATA_W'($urandom_range(0, 8)) - 32'd4;
			8:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
			                                     : 32'h8000_0000 + $urandom_range(0, 3);
			9:       return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Sender: one request in flight, per-request gap, optional hold for drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			gap_left = -1;
		end else begin
			tx_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				load_value(s_tdata, s_tlast);
				tx_valid = 1'b0;
			end
			if (!tx_valid && load_queue.size() > 0) begin
				if (gap_left < 0)
					gap_left = load_queue[0].gap;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!(load_queue[0].drain && sorted_due.size() > 0)) begin
					tx_req = load_queue.pop_front();
					s_tdata <= tx_req.value;
					s_tlast <= tx_req.last;
					tx_valid = 1'b1;
					gap_left = -1;
				end
			end
			s_tvalid <= tx_valid;
		end
	end

	// Receiver: random stalls, switching now and then between busy and calm spells.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sorted_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d", m_tdata));
				end else begin
					got = sorted_due.pop_front();
					if (m_tdata !== got.value)
						report_mismatch($sformatf("sorted_value %0d, want %0d",
							m_tdata, got.value));
					if (m_tlast !== got.last)
						report_mismatch($sformatf("last_out %b, want %b", m_tlast, got.last));
					if (m_tuser !== got.ovf)
						report_mismatch($sformatf("overflow %b, want %b", m_tuser, got.ovf));
				end
				stall_left = rx_busy ? $urandom_range(0, 8) : 0;
				if ($urandom_range(0, 15) == 0)
					rx_busy = !rx_busy;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int  n_rand;
		int  set_no;
		int  big_at;
		int  size;
		int  k;
		bit  busy;
		bit  drain;

		for (k = 0; k < DIR_ITEMS; k++)
			push_req(DIR_VALS[k], DIR_LAST[k], 0, k == 7);

		// one set runs into the store limit; the rest stay small
		big_at = $urandom_range(1, 4);
		set_no = 0;
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			if (set_no == big_at)
				size = $urandom_range(SET_CAP, SET_CAP + 2);
			else if ($urandom_range(0, 3) == 0)
				size = $urandom_range(9, 20);
			else
				size = $urandom_range(1, 8);
			busy  = $urandom_range(0, 2) != 0;
			drain = (set_no == 0) || ($urandom_range(0, 3) == 0);
			for (k = 0; k < size; k++)
				push_req(rand_value(), k == size - 1, busy ? $urandom_range(0, 8) : 0,
					drain && k == 0);
			n_rand += size;
			set_no++;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (load_queue.size() > 0 || s_tvalid || sorted_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/qss_pkg.sv
design/qss_cell.sv
design/qss_chain.sv
design/quicksort_sorter_top.sv
design/qss_checker.sv
sim/quicksort_sorter_top_tb.sv
